### src/cme_pkg.sv
// Package for the covariance matrix engine.
// Control-state encoding, status codes and output limits; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cme_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ERR,
    S_SUM_CHK,
    S_SUM_RD,
    S_SUM_ACC,
    S_MDIV,
    S_MWAIT,
    S_PCHK,
    S_PRD,
    S_PLD,
    S_PROW,
    S_PMUL,
    S_PWR,
    S_ORD,
    S_OWAIT
  } state_e;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_TOO_FEW  = 2'd1;
  localparam status_t STATUS_OVERFLOW = 2'd2;

  localparam logic signed [63:0] COV_MAX = 64'sh0000_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] COV_MIN = -64'sh0001_0000_0000_0000;

endpackage

`default_nettype wire

### src/cme_div.sv
// Sequential signed divider: 64-bit dividend by unsigned divisor, truncates toward zero.
// One quotient bit per cycle. Standalone, no package use.
`timescale 1ns / 1ps
`default_nettype none

module cme_div #(
  parameter int DivW = 14
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic signed [63:0]     dividend_i,
  input  wire logic [DivW-1:0]        divisor_i,
  output logic                        done_o,
  output logic signed [63:0]          quot_o
);

  logic [DivW:0]   rem_q, rem_d;
  logic [63:0]     quo_q, quo_d;
  logic [DivW-1:0] dvs_q, dvs_d;
  logic            neg_q, neg_d;
  logic [6:0]      cnt_q, cnt_d;
  logic            run_q, run_d;
  logic            done_q, done_d;
  logic [DivW:0]   shifted;

  assign shifted = {rem_q[DivW-1:0], quo_q[63]};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i[63] ? 64'(-dividend_i) : 64'(dividend_i);
      dvs_d = divisor_i;
      neg_d = dividend_i[63];
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = shifted - {1'b0, dvs_q};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q + 7'd1;
      if (cnt_q == 7'd63) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule

`default_nettype wire

### src/covariance_matrix_engine_top.sv
// Covariance matrix engine top level: sample store, sum/mean/product passes, output.
// Depends on cme_pkg and cme_div.
//
//   channel   | signals                                   | handshake
//   input     | sample_value_i, last_item_i               | start_i & !busy_o
//   result    | cov_value_o, row_index_o, col_index_o,    | result_valid_o, one cycle
//             | status_o, last_result_o                   |
//   config    | data_dim_i                                | data_dim_we_i
//
// Non-last items are each written into the sample store (one store write port).
// After the last item: setup; sum pass with a read and add per element of a whole
// vector, plus a check per vector and one to finish; a mean division per dimension;
// per vector a check, read and load per element, row fetch per row, multiply and
// write per upper-triangle pair; then accumulator read plus division per matrix entry.
// Reset clears control state only; the sample store is not cleared. No receiver stall.
`timescale 1ns / 1ps
`default_nettype none

module covariance_matrix_engine_top
  import cme_pkg::*;
#(
  parameter int MAX_DIM     = 8,
  parameter int MAX_SAMPLES = 1024
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic signed [15:0] sample_value_i,
  input  wire logic               last_item_i,
  input  wire logic               data_dim_we_i,
  input  wire logic [3:0]         data_dim_i,
  output logic                    result_valid_o,
  output logic signed [48:0]      cov_value_o,
  output logic [2:0]              row_index_o,
  output logic [2:0]              col_index_o,
  output logic [1:0]              status_o,
  output logic                    last_result_o
);

  localparam int Depth = MAX_SAMPLES * MAX_DIM;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);
  localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int KW    = $clog2(MAX_DIM + 1);
  localparam int AccN  = MAX_DIM * MAX_DIM;
  localparam int AAW   = (AccN > 1) ? $clog2(AccN) : 1;
  localparam int SW    = 16 + CW;

  state_e state_q, state_d;

  logic [3:0]    data_dim_q;
  logic [KW-1:0] dim_q;
  logic [CW-1:0] count_q;
  logic          ovf_q;
  logic [CW-1:0] base_q, base_d;
  logic [CW-1:0] nvec_q, nvec_d;
  logic [CW-1:0] vidx_q, vidx_d;
  logic [DW-1:0] r_q, r_d, c_q, c_d;
  logic          first_q, first_d;

  logic signed [SW-1:0] sum_q [MAX_DIM];
  logic signed [24:0]   mean_q [MAX_DIM];
  logic signed [25:0]   delta_q [MAX_DIM];
  logic signed [25:0]   arow_q;
  logic signed [51:0]   prod_q;

  logic signed [15:0] store_mem [Depth];
  logic signed [15:0] store_rd_q;
  logic [AW-1:0]      store_raddr;

  logic [63:0]    acc_mem [AccN];
  logic [63:0]    acc_rd_q;
  logic [AAW-1:0] acc_addr;
  logic           acc_we;
  logic [63:0]    acc_wdata;

  logic               div_start;
  logic signed [63:0] div_dividend;
  logic               div_done;
  logic signed [63:0] div_quot;

  logic          accept;
  logic          last_r, last_c;
  logic [DW-1:0] dsel;
  logic [CW:0]   base_end;
  logic [KW-1:0] dim_clamp;

  logic               out_valid_d;
  logic signed [48:0] out_cov_d;
  status_t            out_status_d;
  logic               out_last_d;

  assign accept = start_i && !busy_o;

  always_comb begin
    if (data_dim_q == 4'd0) begin
      dim_clamp = KW'(1);
    end else if (32'(data_dim_q) > MAX_DIM) begin
      dim_clamp = KW'(MAX_DIM);
    end else begin
      dim_clamp = KW'(data_dim_q);
    end
  end

  assign last_r   = (KW'(r_q) == dim_q - KW'(1));
  assign last_c   = (KW'(c_q) == dim_q - KW'(1));
  assign base_end = {1'b0, base_q} + (CW + 1)'(dim_q);
  assign dsel     = (state_q == S_PROW) ? r_q : c_q;

  // sample store
  always_ff @(posedge clk_i) begin
    if (accept && count_q < CW'(Depth)) begin
      store_mem[count_q[AW-1:0]] <= sample_value_i;
    end
    store_rd_q <= store_mem[store_raddr];
  end
  assign store_raddr = AW'(base_q + CW'(r_q));

  // accumulator store, upper triangle only
  always_comb begin
    if (state_q == S_ORD && r_q > c_q) begin
      acc_addr = AAW'(32'(c_q) * MAX_DIM + 32'(r_q));
    end else begin
      acc_addr = AAW'(32'(r_q) * MAX_DIM + 32'(c_q));
    end
  end
  assign acc_we    = (state_q == S_PWR);
  assign acc_wdata = (first_q ? 64'd0 : acc_rd_q) + 64'(prod_q);

  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_addr] <= acc_wdata;
    end
    acc_rd_q <= acc_mem[acc_addr];
  end

  assign div_start    = (state_q == S_MDIV) || (state_q == S_OWAIT && first_q);
  assign div_dividend = (state_q == S_MDIV) ? 64'(sum_q[r_q]) <<< 8 : $signed(acc_rd_q);

  cme_div #(.DivW(CW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (nvec_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (accept && last_item_i) state_d = S_START;
      S_START:   state_d = (count_q < CW'(dim_q)) ? S_ERR : S_SUM_CHK;
      S_ERR:     state_d = S_IDLE;
      S_SUM_CHK: state_d = (base_end > (CW + 1)'(count_q)) ? S_MDIV : S_SUM_RD;
      S_SUM_RD:  state_d = S_SUM_ACC;
      S_SUM_ACC: state_d = last_r ? S_SUM_CHK : S_SUM_RD;
      S_MDIV:    state_d = S_MWAIT;
      S_MWAIT:   if (div_done) state_d = last_r ? S_PCHK : S_MDIV;
      S_PCHK:    state_d = (vidx_q == nvec_q) ? S_ORD : S_PRD;
      S_PRD:     state_d = S_PLD;
      S_PLD:     state_d = last_r ? S_PROW : S_PRD;
      S_PROW:    state_d = S_PMUL;
      S_PMUL:    state_d = S_PWR;
      S_PWR: begin
        if (!last_c) state_d = S_PMUL;
        else if (last_r) state_d = S_PCHK;
        else state_d = S_PROW;
      end
      S_ORD:     state_d = S_OWAIT;
      S_OWAIT:   if (div_done) state_d = (last_r && last_c) ? S_IDLE : S_ORD;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    base_d  = base_q;
    nvec_d  = nvec_q;
    vidx_d  = vidx_q;
    r_d     = r_q;
    c_d     = c_q;
    first_d = first_q;
    case (state_q)
      S_START: begin
        base_d = '0;
        nvec_d = '0;
        r_d    = '0;
      end
      S_SUM_ACC: begin
        if (last_r) begin
          r_d    = '0;
          base_d = base_q + CW'(dim_q);
          nvec_d = nvec_q + CW'(1);
        end else begin
          r_d = r_q + DW'(1);
        end
      end
      S_MWAIT: begin
        if (div_done) begin
          if (last_r) begin
            r_d     = '0;
            base_d  = '0;
            vidx_d  = '0;
            first_d = 1'b1;
          end else begin
            r_d = r_q + DW'(1);
          end
        end
      end
      S_PCHK: begin
        r_d = '0;
        c_d = '0;
      end
      S_PLD: begin
        r_d = last_r ? '0 : r_q + DW'(1);
        c_d = '0;
      end
      S_PWR: begin
        if (!last_c) begin
          c_d = c_q + DW'(1);
        end else if (last_r) begin
          base_d  = base_q + CW'(dim_q);
          vidx_d  = vidx_q + CW'(1);
          first_d = 1'b0;
        end else begin
          r_d = r_q + DW'(1);
          c_d = r_q + DW'(1);
        end
      end
      S_ORD: begin
        first_d = 1'b1;
      end
      S_OWAIT: begin
        first_d = 1'b0;
        if (div_done) begin
          if (last_c) begin
            c_d = '0;
            r_d = r_q + DW'(1);
          end else begin
            c_d = c_q + DW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // result
  always_comb begin
    out_valid_d  = 1'b0;
    out_cov_d    = '0;
    out_status_d = ovf_q ? STATUS_OVERFLOW : STATUS_OK;
    out_last_d   = 1'b0;
    case (state_q)
      S_ERR: begin
        out_valid_d  = 1'b1;
        out_status_d = STATUS_TOO_FEW;
        out_last_d   = 1'b1;
      end
      S_OWAIT: begin
        out_valid_d = div_done;
        out_last_d  = last_r && last_c;
        if (div_quot > COV_MAX) begin
          out_cov_d = COV_MAX[48:0];
        end else if (div_quot < COV_MIN) begin
          out_cov_d = COV_MIN[48:0];
        end else begin
          out_cov_d = div_quot[48:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      data_dim_q     <= 4'd1;
      dim_q          <= KW'(1);
      count_q        <= '0;
      ovf_q          <= 1'b0;
      base_q         <= '0;
      nvec_q         <= '0;
      vidx_q         <= '0;
      r_q            <= '0;
      c_q            <= '0;
      first_q        <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      base_q         <= base_d;
      nvec_q         <= nvec_d;
      vidx_q         <= vidx_d;
      r_q            <= r_d;
      c_q            <= c_d;
      first_q        <= first_d;
      result_valid_o <= out_valid_d;
      if (data_dim_we_i) begin
        data_dim_q <= data_dim_i;
      end
      if (accept) begin
        dim_q <= dim_clamp;
        if (count_q < CW'(Depth)) begin
          count_q <= count_q + CW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end else if (state_q != S_IDLE && state_d == S_IDLE) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cov_value_o   <= out_cov_d;
    row_index_o   <= 3'(r_q);
    col_index_o   <= 3'(c_q);
    status_o      <= out_status_d;
    last_result_o <= out_last_d;
    if (state_q == S_START) begin
      for (int i = 0; i < MAX_DIM; i++) begin
        sum_q[i] <= '0;
      end
    end else if (state_q == S_SUM_ACC) begin
      sum_q[r_q] <= sum_q[r_q] + SW'(store_rd_q);
    end
    if (state_q == S_MWAIT && div_done) begin
      mean_q[r_q] <= div_quot[24:0];
    end
    if (state_q == S_PLD) begin
      delta_q[r_q] <= {{2{store_rd_q[15]}}, store_rd_q, 8'd0} - 26'(mean_q[r_q]);
    end
    if (state_q == S_PROW) begin
      arow_q <= delta_q[dsel];
    end
    if (state_q == S_PMUL) begin
      prod_q <= arow_q * delta_q[dsel];
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

`default_nettype wire
